>>> rtl/pba_pkg.sv
// Package for the page bitmap allocator: field widths, codes, defaults and
// the word popcount shared by the datapath. No dependencies.
package pba_pkg;

  // Default geometry (handed to the top level as parameter defaults).
  // PAGE_BYTES must be a power of two.
  localparam int NUM_PAGES_DEF  = 256;
  localparam int PAGE_BYTES_DEF = 4096;

  // Flags are stored this many to a memory word.
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = $clog2(WORD_BITS);
  localparam int POPC_W     = $clog2(WORD_BITS + 1);

  // Transaction field widths
  localparam int MODE_W  = 1;
  localparam int BYTES_W = 21;
  localparam int ADDR_W  = 20;
  localparam int FREE_W  = 9;
  localparam int POOL_W  = 9;

  localparam logic [POOL_W-1:0] POOL_RESET = 9'd256;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Count of set bits in one flag word: nibble counts, then an 8-step sum.
  function automatic logic [POPC_W-1:0] popcount_word(input logic [WORD_BITS-1:0] w);
    logic [2:0]        nib [WORD_BITS/4];
    logic [POPC_W-1:0] total;
    for (int i = 0; i < WORD_BITS / 4; i++) begin
      nib[i] = 3'(w[4*i]) + 3'(w[4*i+1]) + 3'(w[4*i+2]) + 3'(w[4*i+3]);
    end
    total = '0;
    for (int i = 0; i < WORD_BITS / 4; i++) begin
      total = total + POPC_W'(nib[i]);
    end
    return total;
  endfunction

endpackage

>>> rtl/pba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the page flag words of the allocator. No dependencies.
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/page_bitmap_allocator.sv
// Page bitmap allocator, top level: request sequencer, range mask unit and
// flag counter around one flag RAM. Depends on pba_pkg and pba_ram.
//
// Usage
//   s_tdata carries one request: mode (0 allocate, 1 free), a byte size and,
//   for a free, a byte address. The size is rounded up to n pages. An
//   allocate takes the first free run of n pages at page 0, n, 2n, ... inside
//   the pool; a free clears n flags from the address's page, clipped to the
//   pool. m_tdata returns one result per request: granted, the run's byte
//   address (0 on refusal and on free) and the pages free after the request.
//   cfg_data writes the pool size in pages; write it only while idle.
// Operation
//   Flags sit WORD_BITS to a RAM word; one range mask / popcount unit works
//   one word at a time (RAM read, then test or update). With W words in the
//   pool RAM, a request tests each word of each candidate slot, updates each
//   word of the run, then recounts all W words for the free pages. A failed
//   slot moves the test on to the next slot of n pages, or ends in refusal
//   once the next slot would pass the pool end.
//   One request is in work at a time; s_tready is low meanwhile.
// Reset and stalls
//   After rst the RAM is cleared one word a cycle with s_tready low. A
//   finished result waits in the output register while m_tready is low;
//   the next request is accepted meanwhile and worked through, then waits
//   in S_DONE until the output register is free.
module page_bitmap_allocator
  import pba_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Request stream: [0] mode, [21:1] request_bytes, [41:22] byte_address
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [47:0]       s_tdata,
  // Result stream: [0] granted, [20:1] page_address, [29:21] free_pages
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,
  // Pool size register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [POOL_W-1:0] cfg_data
);

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int WORDS      = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W      = $clog2(NUM_PAGES + 1);
  localparam int N_W        = BYTES_W + 1 - PAGE_SHIFT;
  localparam int CW         = ((N_W > IDX_W) ? N_W : IDX_W) + 1;
  localparam int PW         = (POOL_W > IDX_W) ? POOL_W : IDX_W;
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_CHK_RD = 9'b000000100,
    S_CHK    = 9'b000001000,
    S_APL_RD = 9'b000010000,
    S_APL_WR = 9'b000100000,
    S_CNT_RD = 9'b001000000,
    S_CNT    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t                state;
  logic [WA_W-1:0]       cur_w;
  logic [CW-1:0]         lo;
  logic [CW-1:0]         hi;
  logic [CW-1:0]         n_run;
  logic                  set_bits;
  logic                  granted;
  logic [CW-1:0]         res_page;
  logic [CW-1:0]         acc;
  logic [POOL_W-1:0]     pool_pages;

  logic                  out_granted;
  logic [ADDR_W-1:0]     out_addr;
  logic [FREE_W-1:0]     out_free;

  // Input field unpacking
  logic                  in_mode;
  logic [BYTES_W-1:0]    in_bytes;
  logic [ADDR_W-1:0]     in_addr;
  logic [BYTES_W:0]      bytes_up;
  logic [CW-1:0]         in_n;
  logic [CW-1:0]         in_start;
  logic [CW-1:0]         in_end;

  assign in_mode  = s_tdata[0];
  assign in_bytes = s_tdata[21:1];
  assign in_addr  = s_tdata[41:22];
  assign bytes_up = {1'b0, in_bytes} + (BYTES_W+1)'(PAGE_BYTES - 1);
  assign in_n     = CW'(bytes_up[BYTES_W:PAGE_SHIFT]);
  assign in_start = CW'(in_addr[ADDR_W-1:PAGE_SHIFT]);
  assign in_end   = in_start + in_n;

  // Pool in effect: min(pool_pages, NUM_PAGES)
  logic [PW-1:0] pool_ext;
  logic [CW-1:0] pool;
  assign pool_ext = PW'(pool_pages);
  assign pool     = (pool_ext < PW'(NUM_PAGES)) ? CW'(pool_ext) : CW'(NUM_PAGES);

  // Flag RAM
  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  pba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_w),
    .wdata (ram_wdata),
    .raddr (cur_w),
    .rdata (ram_rdata)
  );

  // Range mask unit: bits of word cur_w whose page lies in [lo, hi)
  logic [CW-1:0]        word_base;
  logic [WORD_BITS-1:0] mask;
  always_comb begin
    word_base = CW'(cur_w) << WORD_SHIFT;
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = ((word_base | CW'(b)) >= lo) && ((word_base | CW'(b)) < hi);
    end
  end

  logic [CW-1:0]   hi_m1;
  logic [WA_W-1:0] last_w;
  logic [WA_W-1:0] lo_w;
  logic            hit;
  logic [CW-1:0]   next_hi;
  assign hi_m1   = hi - CW'(1);
  assign last_w  = hi_m1[WA_W+WORD_SHIFT-1:WORD_SHIFT];
  assign lo_w    = lo[WA_W+WORD_SHIFT-1:WORD_SHIFT];
  assign hit     = |(ram_rdata & mask);
  assign next_hi = hi + n_run;

  // RAM write data: clear sweep, or set / clear of the masked flags
  assign ram_we    = (state == S_CLEAR) || (state == S_APL_WR);
  assign ram_wdata = (state == S_CLEAR) ? '0 :
                     set_bits ? (ram_rdata | mask) : (ram_rdata & ~mask);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Pool size register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_pages <= POOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pool_pages <= cfg_data;
    end
  end

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cur_w <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (cur_w == LAST_WORD) begin
            cur_w <= '0;
            state <= S_IDLE;
          end else begin
            cur_w <= cur_w + WA_W'(1);
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            n_run    <= in_n;
            res_page <= '0;
            if (in_mode == MODE_ALLOC) begin
              set_bits <= 1'b1;
              granted  <= 1'b0;
              if (in_n == '0 || in_n > pool) begin
                lo    <= '0;
                hi    <= pool;
                acc   <= '0;
                cur_w <= '0;
                state <= S_CNT_RD;
              end else begin
                lo    <= '0;
                hi    <= in_n;
                cur_w <= '0;
                state <= S_CHK_RD;
              end
            end else begin
              set_bits <= 1'b0;
              granted  <= 1'b1;
              if (in_n == '0 || in_start >= pool) begin
                lo    <= '0;
                hi    <= pool;
                acc   <= '0;
                cur_w <= '0;
                state <= S_CNT_RD;
              end else begin
                lo    <= in_start;
                hi    <= (in_end < pool) ? in_end : pool;
                cur_w <= in_start[WA_W+WORD_SHIFT-1:WORD_SHIFT];
                state <= S_APL_RD;
              end
            end
          end
        end
        S_CHK_RD: begin
          state <= S_CHK;
        end
        // Test one word of the candidate slot
        S_CHK: begin
          if (hit) begin
            if (next_hi > pool) begin
              lo    <= '0;
              hi    <= pool;
              acc   <= '0;
              cur_w <= '0;
              state <= S_CNT_RD;
            end else begin
              lo    <= hi;
              hi    <= next_hi;
              cur_w <= hi[WA_W+WORD_SHIFT-1:WORD_SHIFT];
              state <= S_CHK_RD;
            end
          end else if (cur_w == last_w) begin
            cur_w <= lo_w;
            state <= S_APL_RD;
          end else begin
            cur_w <= cur_w + WA_W'(1);
            state <= S_CHK_RD;
          end
        end
        S_APL_RD: begin
          state <= S_APL_WR;
        end
        // Read-modify-write one word of the run
        S_APL_WR: begin
          if (cur_w == last_w) begin
            if (set_bits) begin
              granted  <= 1'b1;
              res_page <= lo;
            end
            lo    <= '0;
            hi    <= pool;
            acc   <= '0;
            cur_w <= '0;
            state <= S_CNT_RD;
          end else begin
            cur_w <= cur_w + WA_W'(1);
            state <= S_APL_RD;
          end
        end
        S_CNT_RD: begin
          state <= S_CNT;
        end
        // Recount used pages inside the pool
        S_CNT: begin
          acc <= acc + CW'(popcount_word(ram_rdata & mask));
          if (cur_w == LAST_WORD) begin
            cur_w <= '0;
            state <= S_DONE;
          end else begin
            cur_w <= cur_w + WA_W'(1);
            state <= S_CNT_RD;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
          cur_w <= '0;
        end
      endcase
    end
  end

  // Output register
  logic [CW+PAGE_SHIFT-1:0] res_bytes;
  logic                     out_load;
  assign res_bytes = {res_page, {PAGE_SHIFT{1'b0}}};
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_granted <= granted;
      out_addr    <= ADDR_W'(res_bytes);
      out_free    <= FREE_W'(pool - acc);
    end
  end

  assign m_tdata = {2'b00, out_free, out_addr, out_granted};

  // Checks
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while a request is in work");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_granted) |-> (out_addr == '0))
    else $error("refused allocation carries a nonzero address");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!s_tready && ram_we && ram_wdata == '0))
    else $error("clear sweep not writing zeros or accepting requests");

  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_CLEAR) || (state == S_APL_WR)))
    else $error("flag RAM written outside clear or update");

endmodule

>>> test/page_bitmap_allocator_checker.sv
// Checker for the page bitmap allocator: watches the request, result and pool
// write channels, tracks the page flags itself and compares every result.
// Depends on pba_pkg.
module page_bitmap_allocator_checker
  import pba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [47:0]       s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [31:0]       m_tdata,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [POOL_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending_results,
  output int                grant_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES_DEF);

  // Request fields, lowest bit first: mode, request_bytes, byte_address
  typedef struct packed {
    logic [ADDR_W-1:0]  byte_address;
    logic [BYTES_W-1:0] request_bytes;
    logic [MODE_W-1:0]  mode;
  } request_t;

  // Result fields, lowest bit first: granted, page_address, free_pages
  typedef struct packed {
    logic [FREE_W-1:0] free_pages;
    logic [ADDR_W-1:0] page_address;
    logic              granted;
  } result_t;

  bit [NUM_PAGES_DEF-1:0] used_map;
  logic [POOL_W-1:0]      pool_reg;
  result_t                replies_due[$];
  int                     results_seen;

  task automatic report_mismatch(input string what);
    $display("%0t ns: result %0d mismatch: %s", $time, results_seen, what);
    fail_count++;
  endtask

  // Applies one request to the flag map and returns the result it yields
  function automatic result_t apply_request(input request_t req);
    int      pool;
    int      pages;
    int      base;
    int      start;
    int      used;
    bit      fits;
    result_t res;
    pool  = (pool_reg < NUM_PAGES_DEF) ? int'(pool_reg) : NUM_PAGES_DEF;
    pages = (int'(req.request_bytes) + PAGE_BYTES_DEF - 1) >> PAGE_SHIFT;
    res   = '0;
    if (req.mode == MODE_ALLOC) begin
      // first fit over slots aligned to the run size
      if (pages != 0 && pages <= pool) begin
        for (base = 0; base + pages <= pool && !res.granted; base += pages) begin
          fits = 1'b1;
          for (int k = 0; k < pages; k++) begin
            if (used_map[base + k]) fits = 1'b0;
          end
          if (fits) begin
            for (int k = 0; k < pages; k++) used_map[base + k] = 1'b1;
            res.granted      = 1'b1;
            res.page_address = ADDR_W'(base << PAGE_SHIFT);
          end
        end
      end
    end else begin
      // free clipped at the pool end
      start = int'(req.byte_address) >> PAGE_SHIFT;
      for (int k = 0; k < pages && start + k < pool; k++) used_map[start + k] = 1'b0;
      res.granted = 1'b1;
    end
    used = 0;
    for (int k = 0; k < pool; k++) used += used_map[k];
    res.free_pages = FREE_W'(pool - used);
    return res;
  endfunction

  // Channel monitor: register writes, requests in, results out
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst) begin
      used_map     = '0;
      pool_reg     = POOL_RESET;
      replies_due.delete();
      fail_count   = 0;
      grant_count  = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) pool_reg = cfg_data;
      if (s_tvalid && s_tready) begin
        replies_due.push_back(apply_request(request_t'(s_tdata[41:0])));
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[29:0]);
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", got));
        end else begin
          want = replies_due.pop_front();
          if (got.granted != want.granted)
            report_mismatch($sformatf("granted %0b, want %0b", got.granted, want.granted));
          if (got.page_address != want.page_address)
            report_mismatch($sformatf("page_address %h, want %h",
                                      got.page_address, want.page_address));
          if (got.free_pages != want.free_pages)
            report_mismatch($sformatf("free_pages %0d, want %0d",
                                      got.free_pages, want.free_pages));
          if (want.granted && want.page_address != '0) grant_count++;
          else if (want.granted && want.free_pages != FREE_W'(NUM_PAGES_DEF)) grant_count++;
        end
        results_seen++;
      end
    end
    pending_results <= replies_due.size();
  end

endmodule

>>> test/tb_page_bitmap_allocator.sv
// Testbench top for the page bitmap allocator: clock, reset, request and pool
// write stimulus, result back-pressure and the verdict. Depends on pba_pkg,
// page_bitmap_allocator and page_bitmap_allocator_checker.
module tb_page_bitmap_allocator
  import pba_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES_DEF);
  localparam int STALL_LIMIT = 20000;
  localparam int NUM_PHASES  = 12;
  // pool size of each phase (-1 draws one) and its random request count
  localparam int PHASE_POOL[NUM_PHASES]  = '{256, 0, 1, 2, 511, 37, 256, 64, 255, 300,
                                             -1, 256};
  localparam int PHASE_ITEMS[NUM_PHASES] = '{150, 30, 60, 60, 180, 160, 180, 160, 180,
                                             160, 180, 150};

  logic              clk;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [47:0]       s_tdata   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [31:0]       m_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [POOL_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending_results;
  int grant_count;
  int tx_gap_max    = 15;
  int rx_stall_max  = 15;
  int requests_sent = 0;
  int pool_writes   = 0;
  int idle_cycles   = 0;
  int pool_now      = NUM_PAGES_DEF;

  page_bitmap_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [0] mode, [21:1] request_bytes, [41:22] byte_address
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [0] granted, [20:1] page_address, [29:21] free_pages
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  page_bitmap_allocator_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .grant_count     (grant_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: ends the run after too long without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result sink: random stall before each result, then hold ready until taken
  initial begin : result_sink
    int stall;
    forever begin
      stall = $urandom_range(rx_stall_max, 0);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic send_request(input logic mode, input logic [BYTES_W-1:0] bytes,
                              input logic [ADDR_W-1:0] addr);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, addr, bytes, mode};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    requests_sent++;
  endtask

  // Stop requesting and wait until every result has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pool(input int pages);
    cfg_valid <= 1'b1;
    cfg_data  <= POOL_W'(pages);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    pool_now = (pages < NUM_PAGES_DEF) ? pages : NUM_PAGES_DEF;
    pool_writes++;
  endtask

  // Run length in pages: mostly small powers of two, capped by the pool
  function automatic int pick_pages(input int limit);
    int pages;
    if (limit < 1) return 1;
    if ($urandom_range(9, 0) < 6) pages = 1 << $urandom_range(3, 0);
    else pages = $urandom_range((limit < 40) ? limit : 40, 1);
    return (pages > limit) ? limit : pages;
  endfunction

  // Byte size that rounds up to exactly the given page count
  function automatic logic [BYTES_W-1:0] pages_to_bytes(input int pages);
    return BYTES_W'((pages - 1) * PAGE_BYTES_DEF + $urandom_range(PAGE_BYTES_DEF, 1));
  endfunction

  task automatic random_request();
    int                 pick;
    int                 pages;
    int                 slots;
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] bytes;
    pick  = $urandom_range(99, 0);
    pages = pick_pages(pool_now);
    slots = (pool_now >= pages) ? pool_now / pages : 1;
    addr  = ADDR_W'(($urandom_range(slots - 1, 0) * pages) << PAGE_SHIFT);
    bytes = pages_to_bytes(pages);
    if (pick < 50) begin
      // address is ignored on allocate
      send_request(MODE_ALLOC, bytes, ADDR_W'($urandom));
    end else if (pick < 80) begin
      send_request(MODE_FREE, bytes, addr);
    end else if (pick < 86) begin
      // unaligned free address
      send_request(MODE_FREE, bytes, addr | ADDR_W'($urandom_range(PAGE_BYTES_DEF - 1, 0)));
    end else if (pick < 93) begin
      // full-width noise
      send_request(1'($urandom), BYTES_W'($urandom), ADDR_W'($urandom));
    end else if (pick < 96) begin
      send_request(1'($urandom), '0, ADDR_W'($urandom));
    end else begin
      // whole pool at once
      send_request(1'($urandom), BYTES_W'(pool_now << PAGE_SHIFT), '0);
    end
  endtask

  initial begin : stimulus
    int pool;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // some phases run without gaps on one or both sides
      tx_gap_max   = (phase % 4 == 2 || phase % 4 == 3) ? 0 : 15;
      rx_stall_max = (phase % 4 == 2) ? 0 : 15;
      pool = (PHASE_POOL[phase] < 0) ? $urandom_range(NUM_PAGES_DEF, 1) : PHASE_POOL[phase];
      write_pool(pool);

      if (phase == 0) begin
        // zero size, single pages, a two-page run, a whole-pool run and an oversized run
        send_request(MODE_ALLOC, '0, '0);
        send_request(MODE_ALLOC, 21'd1, '0);
        send_request(MODE_ALLOC, 21'd4096, 20'hFFFFF);
        send_request(MODE_ALLOC, 21'd4097, '0);
        send_request(MODE_ALLOC, 21'd1048576, '0);
        send_request(MODE_ALLOC, 21'h1FFFFF, '0);
        // zero size free, unaligned free, double free, free past the pool end
        send_request(MODE_FREE, '0, '0);
        send_request(MODE_FREE, 21'd4096, 20'h01234);
        send_request(MODE_FREE, 21'd4096, 20'h01000);
        send_request(MODE_FREE, 21'h1FFFFF, 20'hFFFFF);
        send_request(MODE_ALLOC, 21'd131072, '0);
        // clear all, fill the pool, refuse when full
        send_request(MODE_FREE, 21'd1048576, '0);
        send_request(MODE_ALLOC, 21'd1048576, '0);
        send_request(MODE_ALLOC, 21'd1, '0);
        send_request(MODE_FREE, 21'd32768, 20'hF8000);
        send_request(MODE_ALLOC, 21'd32768, '0);
        send_request(MODE_FREE, 21'd1048576, '0);
        send_request(MODE_ALLOC, 21'd12288, '0);
      end

      for (int i = 0; i < PHASE_ITEMS[phase]; i++) random_request();
      drain();
    end

    repeat (64) @(posedge clk);
    $display("Ran %0d requests over %0d pool sizes (empty to oversized); %0d grants seen.",
             requests_sent, pool_writes, grant_count);
    if (fail_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
